FILE: src/dsv_pkg.sv
// Shared types and constants for the drowsiness status voter.
package dsv_pkg;

    // Status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_DROWSY = 3'd1;
    localparam logic [2:0] ST_YAWN   = 3'd2;
    localparam logic [2:0] ST_LEFT   = 3'd3;
    localparam logic [2:0] ST_RIGHT  = 3'd4;
    localparam logic [2:0] ST_DOWN   = 3'd5;
    localparam logic [2:0] ST_UP     = 3'd6;

    // Configuration register indexes
    localparam logic [2:0] REG_EYE_DEF   = 3'd0;
    localparam logic [2:0] REG_EYE_FLOOR = 3'd1;
    localparam logic [2:0] REG_YAWN      = 3'd2;
    localparam logic [2:0] REG_YAW_LIM   = 3'd3;
    localparam logic [2:0] REG_PITCH_LIM = 3'd4;
    localparam logic [2:0] REG_CLOSED_MS = 3'd5;
    localparam logic [2:0] REG_VOTE_LIM  = 3'd6;
    localparam logic [2:0] REG_CALIB_FR  = 3'd7;

    localparam int NUM_LANES = 4;

    // Per-lane control toward the median lanes
    typedef struct packed {
        logic push;   // shift the new sample into the window
        logic start;  // begin the median search
    } t_lane_ctl;

endpackage

FILE: src/dsv_median_lane.sv
// One median lane: sample window and a rank search over one slot per cycle.
module dsv_median_lane
    import dsv_pkg::*;
#(
    parameter int WINDOW_LEN  = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctl                     i_ctl,
    input  logic                          i_signed,
    input  logic [SAMPLE_BITS-1:0]        i_sample,
    input  logic [$clog2(WINDOW_LEN+1)-1:0] i_fill,
    output logic [SAMPLE_BITS-1:0]        o_median,
    output logic                          o_done
);
    localparam int FW = $clog2(WINDOW_LEN + 1);
    localparam int IW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    logic [SAMPLE_BITS-1:0] r_hist [WINDOW_LEN];
    logic [IW-1:0]          r_idx;
    logic                   r_busy;
    logic                   r_done;
    logic [SAMPLE_BITS-1:0] r_median;

    // Map to an order-preserving unsigned key
    function automatic logic [SAMPLE_BITS-1:0] key(input logic [SAMPLE_BITS-1:0] v,
                                                   input logic sgn);
        key = {v[SAMPLE_BITS-1] ^ sgn, v[SAMPLE_BITS-2:0]};
    endfunction

    logic [FW-1:0]          base;
    logic [SAMPLE_BITS-1:0] cand;
    logic [FW-1:0]          n_less;
    logic [FW-1:0]          n_le;
    logic [FW-1:0]          mid;
    logic                   in_win;

    // Rank the candidate against the valid part of the window
    always_comb begin
        base   = FW'(WINDOW_LEN) - i_fill;
        cand   = r_hist[r_idx];
        n_less = '0;
        n_le   = '0;
        mid    = i_fill >> 1;
        in_win = ({1'b0, r_idx} >= {1'b0, base});
        for (int k = 0; k < WINDOW_LEN; k++) begin
            if (FW'(k) >= base) begin
                if (key(r_hist[k], i_signed) < key(cand, i_signed))
                    n_less = n_less + 1'b1;
                if (key(r_hist[k], i_signed) <= key(cand, i_signed))
                    n_le = n_le + 1'b1;
            end
        end
    end

    // Shift the window; newest sample at the top slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            for (int k = 0; k < WINDOW_LEN - 1; k++)
                r_hist[k] <= r_hist[k+1];
            r_hist[WINDOW_LEN-1] <= i_sample;
        end
    end

    // Walk the slots for the candidate of rank fill/2; zero if none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (in_win && n_less <= mid && n_le > mid) begin
                    r_median <= cand;
                    r_busy   <= 1'b0;
                    r_done   <= 1'b1;
                end else if (r_idx == IW'(WINDOW_LEN - 1)) begin
                    r_median <= '0;
                    r_busy   <= 1'b0;
                    r_done   <= 1'b1;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_median = r_median;
    assign o_done   = r_done;
endmodule

FILE: src/dsv_divider.sv
// Restoring divider for the calibration threshold (sum*3 / (5*count)).
module dsv_divider
    import dsv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [25:0] i_num,
    input  logic [10:0] i_den,
    output logic [25:0] o_quot,
    output logic        o_done
);
    logic [25:0] r_quot;
    logic [25:0] r_num;
    logic [10:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [11:0] trial;
    logic [11:0] diff;

    always_comb begin
        trial = {r_rem, r_num[25]};
        diff  = trial - {1'b0, i_den};
    end

    // One quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[24:0], 1'b0};
                if (!diff[11]) begin
                    r_rem  <= diff[10:0];
                    r_quot <= {r_quot[24:0], 1'b1};
                end else begin
                    r_rem  <= trial[10:0];
                    r_quot <= {r_quot[24:0], 1'b0};
                end
                if (r_cnt == 5'd25) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;
endmodule

FILE: src/drowsiness_status_voter.sv
// Top level of the drowsiness status voter: lanes, merge, calibration, votes.
//
// Usage: one face measurement beat per video frame enters on the s_axis
// channel; exactly one status beat leaves on the m_axis channel for each.
// Configuration registers are written on i_cfg_we/i_cfg_idx/i_cfg_data while
// the block is idle and take effect on the next frame.
// Work on a frame: the four median lanes each search their window one slot per
// cycle; the frame that ends calibration then runs the bit-serial divider;
// the merge then loads the output register. One frame is in work at a time;
// s_axis_tready is high whenever no frame is in work and the output register
// is free or being drained.
// The next frame can be accepted in the cycle its predecessor's beat leaves.
// Reset (synchronous, active low) empties the windows, clears calibration,
// vote and blink counters and loads the register defaults.
// A stalled receiver holds the result in the output register; no new frame
// is accepted until that beat leaves, so the input stalls with it.
module drowsiness_status_voter
    import dsv_pkg::*;
#(
    parameter int WINDOW_LEN  = 5,
    parameter int SAMPLE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] eye_ratio, [31:16] mouth_ratio, [46:32] yaw_angle,
    // [61:47] pitch_angle, [93:62] time_ms, [95:94] zero
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status_code, [3] calibrated, [19:4] blink_total,
    // [35:20] eye_median, [51:36] mouth_median, [66:52] yaw_median,
    // [81:67] pitch_median, [97:82] eye_threshold_now, [103:98] zero
    output logic [103:0] m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    localparam int FW = $clog2(WINDOW_LEN + 1);
    localparam int SB = SAMPLE_BITS;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MED   = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_MERGE = 2'd3;

    // Configuration registers
    logic [15:0] r_eye_def, r_eye_floor, r_yawn, r_closed_ms;
    logic [13:0] r_yaw_lim, r_pitch_lim;
    logic [7:0]  r_vote_lim, r_calib_fr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye_def   <= 16'd4096;
            r_eye_floor <= 16'd2458;
            r_yawn      <= 16'd9011;
            r_yaw_lim   <= 14'd3840;
            r_pitch_lim <= 14'd3840;
            r_closed_ms <= 16'd1000;
            r_vote_lim  <= 8'd3;
            r_calib_fr  <= 8'd30;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EYE_DEF:   r_eye_def   <= i_cfg_data;
                REG_EYE_FLOOR: r_eye_floor <= i_cfg_data;
                REG_YAWN:      r_yawn      <= i_cfg_data;
                REG_YAW_LIM:   r_yaw_lim   <= i_cfg_data[13:0];
                REG_PITCH_LIM: r_pitch_lim <= i_cfg_data[13:0];
                REG_CLOSED_MS: r_closed_ms <= i_cfg_data;
                REG_VOTE_LIM:  r_vote_lim  <= i_cfg_data[7:0];
                REG_CALIB_FR:  r_calib_fr  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Control state
    logic [1:0]  r_state, n_state;
    logic [FW-1:0] r_fill;
    logic [31:0] r_time;
    logic [23:0] r_calib_sum;
    logic [7:0]  r_calib_cnt;
    logic        r_calib_done;
    logic [15:0] r_eye_thr;
    logic        r_eye_closed;
    logic [31:0] r_closed_since;
    logic [7:0]  r_votes [5];
    logic [15:0] r_blinks;
    logic [NUM_LANES-1:0] r_lane_done;
    logic        r_out_valid;
    logic [103:0] r_out_data;

    logic      accept;
    logic      out_take;
    t_lane_ctl lane_ctl;

    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign lane_ctl.push  = accept;
    assign lane_ctl.start = accept;

    // Sample conversion into SAMPLE_BITS storage
    logic [SB-1:0] smp [NUM_LANES];
    logic [NUM_LANES-1:0] sgn_lane;
    assign smp[0] = SB'(s_axis_tdata[15:0]);
    assign smp[1] = SB'(s_axis_tdata[31:16]);
    assign smp[2] = SB'($signed(s_axis_tdata[46:32]));
    assign smp[3] = SB'($signed(s_axis_tdata[61:47]));
    assign sgn_lane = 4'b1100;

    logic [SB-1:0] med [NUM_LANES];
    logic [NUM_LANES-1:0] lane_done;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        dsv_median_lane #(
            .WINDOW_LEN (WINDOW_LEN),
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl),
            .i_signed(sgn_lane[g]),
            .i_sample(smp[g]),
            .i_fill  (r_fill),
            .o_median(med[g]),
            .o_done  (lane_done[g])
        );
    end

    // Calibration step on the eye median (taken as unsigned)
    logic [SB:0]  em_x;
    logic [24:0]  sum_w;
    logic [23:0]  sum_sat;
    logic [7:0]   cnt_inc;
    logic         calib_fin;
    logic [25:0]  div_num;
    logic [10:0]  div_den;
    logic         div_start;
    logic [25:0]  quot;
    logic         div_done;

    always_comb begin
        em_x      = {1'b0, med[0]};
        sum_w     = {1'b0, r_calib_sum} + 25'(em_x);
        sum_sat   = (sum_w > 25'hFFFFFF) ? 24'hFFFFFF : sum_w[23:0];
        cnt_inc   = (r_calib_cnt == 8'd255) ? r_calib_cnt : r_calib_cnt + 8'd1;
        calib_fin = !r_calib_done && (cnt_inc >= r_calib_fr);
        div_num   = ({2'b0, sum_sat} << 1) + {2'b0, sum_sat};
        div_den   = ({3'b0, cnt_inc} << 2) + {3'b0, cnt_inc};
        div_start = (r_state == S_MED) && (&(r_lane_done | lane_done)) && calib_fin;
    end

    dsv_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_quot (quot),
        .o_done (div_done)
    );

    // Merge: threshold, eye state, votes and status
    logic [15:0] thr;
    logic [15:0] q_clip;
    logic [15:0] new_thr;
    logic        will_done;
    logic signed [SB:0] ym_s, pm_s, ya_s;
    logic        closed_now;
    logic [31:0] dur;
    logic [4:0]  vup;
    logic [7:0]  n_votes [5];
    logic [2:0]  status;
    logic [15:0] n_blinks;

    always_comb begin
        q_clip    = (quot > 26'hFFFF) ? 16'hFFFF : quot[15:0];
        new_thr   = (q_clip < r_eye_floor) ? r_eye_floor : q_clip;
        will_done = r_calib_done || calib_fin;
        thr       = r_calib_done ? r_eye_thr : (calib_fin ? new_thr : r_eye_def);
        ym_s      = $signed({med[2][SB-1], med[2]});
        pm_s      = $signed({med[3][SB-1], med[3]});
        ya_s      = ym_s[SB] ? -ym_s : ym_s;
        closed_now = {1'b0, med[0]} < (SB+1)'(thr);
        dur       = r_time - r_closed_since;
        vup[0]    = closed_now && r_eye_closed && (dur > {16'd0, r_closed_ms});
        vup[1]    = {1'b0, med[1]} > (SB+1)'(r_yawn);
        vup[2]    = ya_s > $signed((SB+1)'(r_yaw_lim));
        vup[3]    = pm_s > $signed((SB+1)'(r_pitch_lim));
        vup[4]    = pm_s < -$signed((SB+1)'(r_pitch_lim));
        for (int v = 0; v < 5; v++) begin
            if (vup[v])
                n_votes[v] = (r_votes[v] == 8'd255) ? r_votes[v] : r_votes[v] + 8'd1;
            else if (v == 0 && closed_now)
                n_votes[v] = r_votes[v];
            else
                n_votes[v] = (r_votes[v] == 8'd0) ? r_votes[v] : r_votes[v] - 8'd1;
        end
        n_blinks = (!closed_now && r_eye_closed && r_blinks != 16'hFFFF) ?
                   r_blinks + 16'd1 : r_blinks;
        if (n_votes[0] >= r_vote_lim)      status = ST_DROWSY;
        else if (n_votes[1] >= r_vote_lim) status = ST_YAWN;
        else if (n_votes[2] >= r_vote_lim) status = (ym_s > 0) ? ST_LEFT : ST_RIGHT;
        else if (n_votes[3] >= r_vote_lim) status = ST_DOWN;
        else if (n_votes[4] >= r_vote_lim) status = ST_UP;
        else                               status = ST_OK;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_MED;
            S_MED:   if (&(r_lane_done | lane_done))
                         n_state = calib_fin ? S_DIV : S_MERGE;
            S_DIV:   if (div_done) n_state = S_MERGE;
            S_MERGE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept)
            r_time <= s_axis_tdata[93:62];
        if (r_state == S_MERGE)
            r_out_data <= {6'd0, thr, 15'(pm_s), 15'(ym_s), 16'(med[1]),
                           16'(med[0]), n_blinks, will_done, status};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_fill         <= '0;
            r_calib_sum    <= '0;
            r_calib_cnt    <= '0;
            r_calib_done   <= 1'b0;
            r_eye_thr      <= 16'd4096;
            r_eye_closed   <= 1'b0;
            r_closed_since <= '0;
            r_blinks       <= '0;
            r_lane_done    <= '0;
            r_out_valid    <= 1'b0;
            for (int v = 0; v < 5; v++) r_votes[v] <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_lane_done <= '0;
                if (r_fill != FW'(WINDOW_LEN)) r_fill <= r_fill + 1'b1;
            end else begin
                r_lane_done <= r_lane_done | lane_done;
            end
            // Commit the frame's state updates
            if (r_state == S_MERGE) begin
                r_out_valid <= 1'b1;
                if (!r_calib_done) begin
                    r_calib_sum <= sum_sat;
                    r_calib_cnt <= cnt_inc;
                    if (calib_fin) begin
                        r_calib_done <= 1'b1;
                        r_eye_thr    <= new_thr;
                    end
                end
                if (closed_now && !r_eye_closed) begin
                    r_closed_since <= r_time;
                    r_eye_closed   <= 1'b1;
                end else if (!closed_now) begin
                    r_eye_closed <= 1'b0;
                end
                r_blinks <= n_blinks;
                for (int v = 0; v < 5; v++) r_votes[v] <= n_votes[v];
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    // An accepted frame is always followed by the median-search state
    a_one_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_MED) else $error("frame overlap");
    // A merge always produces a valid output beat
    a_merge_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MERGE |=> r_out_valid) else $error("merge lost result");
    // Divider results arrive only in the divide state
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV) else $error("stray divide");
`endif
endmodule
